FILE: sv/adtsd_pkg.sv
// Shared types, constants and the sample rate table for the ADTS header deframer.
package adtsd_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned PROFILE_W  = 2;
	localparam int unsigned SIDX_W     = 4;
	localparam int unsigned RATE_W     = 17;
	localparam int unsigned CHCFG_W    = 3;
	localparam int unsigned LEN_W      = 13;
	localparam int unsigned FNUM_W     = 16;
	localparam int unsigned OFFSET_W   = 32;
	localparam int unsigned HDR_POS_W  = 3;

	localparam logic [BYTE_W-1:0]    SYNC_BYTE     = 8'hFF;
	localparam logic [3:0]           SYNC_NIBBLE   = 4'hF;
	localparam logic [LEN_W-1:0]     HDR_BYTES     = 13'd7;
	localparam logic [HDR_POS_W-1:0] HDR_POS_FIRST = 3'd2;
	localparam logic [HDR_POS_W-1:0] HDR_POS_LAST  = 3'd6;
	localparam logic [OFFSET_W-1:0]  OFFSET_BACK   = 32'd6;

	typedef struct packed {
		logic [PROFILE_W-1:0] profile;
		logic [SIDX_W-1:0]    sampling_index;
		logic [RATE_W-1:0]    sample_rate_hz;
		logic [CHCFG_W-1:0]   channel_config;
		logic                 crc_absent;
		logic [LEN_W-1:0]     frame_length;
		logic [FNUM_W-1:0]    frame_number;
		logic [OFFSET_W-1:0]  frame_offset;
		logic                 length_error;
	} adtsd_result_t;

	function automatic logic [RATE_W-1:0] sample_rate(input logic [SIDX_W-1:0] idx);
		logic [RATE_W-1:0] r;
		case (idx)
			4'd0:    r = 17'd96000;
			4'd1:    r = 17'd88200;
			4'd2:    r = 17'd64000;
			4'd3:    r = 17'd48000;
			4'd4:    r = 17'd44100;
			4'd5:    r = 17'd32000;
			4'd6:    r = 17'd24000;
			4'd7:    r = 17'd22050;
			4'd8:    r = 17'd16000;
			4'd9:    r = 17'd12000;
			4'd10:   r = 17'd11025;
			4'd11:   r = 17'd8000;
			4'd12:   r = 17'd7350;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/adtsd_in_if.sv
// Byte input channel: valid/ready handshake with one stream byte.
interface adtsd_in_if
	import adtsd_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] stream_byte;

	modport source(output valid, output stream_byte, input ready);
	modport sink(input valid, input stream_byte, output ready);
endinterface

FILE: sv/adtsd_out_if.sv
// Result channel: valid/ready handshake with the decoded header fields.
interface adtsd_out_if
	import adtsd_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [PROFILE_W-1:0] profile;
	logic [SIDX_W-1:0]    sampling_index;
	logic [RATE_W-1:0]    sample_rate_hz;
	logic [CHCFG_W-1:0]   channel_config;
	logic                 crc_absent;
	logic [LEN_W-1:0]     frame_length;
	logic [FNUM_W-1:0]    frame_number;
	logic [OFFSET_W-1:0]  frame_offset;
	logic                 length_error;

	modport source(output valid, output profile, output sampling_index,
		output sample_rate_hz, output channel_config, output crc_absent,
		output frame_length, output frame_number, output frame_offset,
		output length_error, input ready);
	modport sink(input valid, input profile, input sampling_index,
		input sample_rate_hz, input channel_config, input crc_absent,
		input frame_length, input frame_number, input frame_offset,
		input length_error, output ready);
endinterface

FILE: sv/adtsd_parser.sv
// Sync hunt, header capture and payload skip; decodes the header on its last byte.
module adtsd_parser
	import adtsd_pkg::*;
#(
	parameter int unsigned FRAME_COUNT_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] byte_in,
	output logic              res_valid,
	output adtsd_result_t     res
);

	typedef enum logic [1:0] {
		PH_SYNC    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	phase_t                      phase_q;
	logic [BYTE_W-1:0]           prev_q;
	logic [HDR_POS_W-1:0]        pos_q;
	logic [LEN_W-1:0]            remain_q;
	logic [FRAME_COUNT_BITS-1:0] cnt_q;
	logic [OFFSET_W-1:0]         bpos_q;
	logic [BYTE_W-1:0]           hdr_q [1:5];

	logic [LEN_W-1:0] len;
	logic             short_len;
	logic [31:0]      cnt_ext;
	logic [LEN_W-1:0] remain_dec;

	assign len = {hdr_q[3][1:0], hdr_q[4], hdr_q[5][7:5]};
	assign short_len = len < HDR_BYTES;
	assign cnt_ext = 32'(cnt_q);
	assign remain_dec = (remain_q != '0) ? remain_q - 1'b1 : remain_q;

	assign res_valid = step && (phase_q == PH_HEADER) && (pos_q == HDR_POS_LAST);

	always_comb begin
		res.profile        = hdr_q[2][7:6];
		res.sampling_index = hdr_q[2][5:2];
		res.sample_rate_hz = sample_rate(hdr_q[2][5:2]);
		res.channel_config = {hdr_q[2][0], hdr_q[3][7:6]};
		res.crc_absent     = hdr_q[1][0];
		res.frame_length   = len;
		res.frame_number   = cnt_ext[FNUM_W-1:0];
		res.frame_offset   = bpos_q - OFFSET_BACK;
		res.length_error   = short_len;
	end

	// header bytes 1..5 are kept; byte 6 carries nothing that is decoded
	always_ff @(posedge clk) begin
		if (step) begin
			if (phase_q == PH_HEADER) begin
				case (pos_q)
					3'd2:    hdr_q[2] <= byte_in;
					3'd3:    hdr_q[3] <= byte_in;
					3'd4:    hdr_q[4] <= byte_in;
					3'd5:    hdr_q[5] <= byte_in;
					default: ;
				endcase
			end else if (phase_q != PH_PAYLOAD) begin
				hdr_q[1] <= byte_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC;
			prev_q   <= '0;
			pos_q    <= '0;
			remain_q <= '0;
			cnt_q    <= '0;
			bpos_q   <= '0;
		end else if (step) begin
			bpos_q <= bpos_q + 1'b1;
			unique case (phase_q)
				PH_HEADER: begin
					if (pos_q == HDR_POS_LAST) begin
						cnt_q  <= cnt_q + 1'b1;
						pos_q  <= '0;
						prev_q <= '0;
						if (short_len || len == HDR_BYTES) begin
							phase_q  <= PH_SYNC;
							remain_q <= '0;
						end else begin
							phase_q  <= PH_PAYLOAD;
							remain_q <= len - HDR_BYTES;
						end
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				PH_PAYLOAD: begin
					remain_q <= remain_dec;
					if (remain_dec == '0) begin
						phase_q <= PH_SYNC;
						prev_q  <= '0;
					end
				end
				default: begin
					// unused phase code hunts like sync search
					phase_q <= PH_SYNC;
					if (prev_q == SYNC_BYTE && byte_in[7:4] == SYNC_NIBBLE) begin
						phase_q <= PH_HEADER;
						pos_q   <= HDR_POS_FIRST;
						prev_q  <= '0;
					end else begin
						prev_q <= byte_in;
					end
				end
			endcase
		end
	end

endmodule

FILE: sv/adtsd_out_stage.sv
// Result register driving the output channel.
module adtsd_out_stage
	import adtsd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  logic          load_valid,
	input  adtsd_result_t load_res,
	output logic          can_load,
	adtsd_out_if.source   out_ch
);

	logic          valid_s2;
	adtsd_result_t res_s2;

	assign can_load = !valid_s2 || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= load_valid;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_valid) begin
			res_s2 <= load_res;
		end
	end

	assign out_ch.valid          = valid_s2;
	assign out_ch.profile        = res_s2.profile;
	assign out_ch.sampling_index = res_s2.sampling_index;
	assign out_ch.sample_rate_hz = res_s2.sample_rate_hz;
	assign out_ch.channel_config = res_s2.channel_config;
	assign out_ch.crc_absent     = res_s2.crc_absent;
	assign out_ch.frame_length   = res_s2.frame_length;
	assign out_ch.frame_number   = res_s2.frame_number;
	assign out_ch.frame_offset   = res_s2.frame_offset;
	assign out_ch.length_error   = res_s2.length_error;

endmodule

FILE: sv/adts_header_deframer_top.sv
// ADTS header deframer top level: input register, parser and result register.
//
//  channel  | dir | handshake   | payload
//  ---------+-----+-------------+---------------------------------------------
//  in_ch    | in  | valid/ready | stream_byte[7:0]
//  out_ch   | out | valid/ready | one decoded ADTS header per frame
//
// One byte per cycle sustained while out_ch is not stalled; the last header byte is held in
// the input register, and its result is valid on out_ch once loaded into the result register.
// The parser updates its state once per byte, so nothing limits the rate
// except backpressure on out_ch, which stalls the input register and then in_ch.
// arst_n clears the phase, counters and valid flags; no clearing pass is needed.
module adts_header_deframer_top
	import adtsd_pkg::*;
#(
	parameter int unsigned FRAME_COUNT_BITS = 16
) (
	input logic         clk,
	input logic         arst_n,
	adtsd_in_if.sink    in_ch,
	adtsd_out_if.source out_ch
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              can_load;
	logic              advance;
	logic              res_valid;
	adtsd_result_t     res;

	assign advance     = valid_s1 && can_load;
	assign in_ch.ready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.stream_byte;
		end
	end

	adtsd_parser #(
		.FRAME_COUNT_BITS(FRAME_COUNT_BITS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.byte_in  (byte_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	adtsd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.load_valid(res_valid),
		.load_res  (res),
		.can_load  (can_load),
		.out_ch    (out_ch)
	);

endmodule

FILE: sv/adtsd_checker.sv
// Port-level assertions for the ADTS header deframer, bound to the top level.
module adtsd_checker
	import adtsd_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic [SIDX_W-1:0]   sampling_index,
	input logic [RATE_W-1:0]   sample_rate_hz,
	input logic [LEN_W-1:0]    frame_length,
	input logic                length_error,
	input logic [OFFSET_W-1:0] frame_offset
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_offset))
		else $error("result dropped or changed while stalled");

	a_len_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (length_error == (frame_length < HDR_BYTES)))
		else $error("length_error disagrees with frame_length");

	a_rate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((sampling_index >= 4'd13) == (sample_rate_hz == '0)))
		else $error("sample rate does not match index");

endmodule

bind adts_header_deframer_top adtsd_checker u_adtsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.sampling_index(out_ch.sampling_index),
	.sample_rate_hz(out_ch.sample_rate_hz),
	.frame_length  (out_ch.frame_length),
	.length_error  (out_ch.length_error),
	.frame_offset  (out_ch.frame_offset)
);

FILE: dv/tb_adts_header_deframer_top.sv
// Self-checking testbench for adts_header_deframer_top: directed and random byte streams.
module tb_adts_header_deframer_top
	import adtsd_pkg::*;
();

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned RANDOM_BYTES = 1000;

	typedef enum logic [1:0] {HUNT, HEADER, PAYLOAD} deframe_phase_t;

	localparam logic [RATE_W-1:0] RATE_LUT [16] = '{
		17'd96000, 17'd88200, 17'd64000, 17'd48000, 17'd44100, 17'd32000,
		17'd24000, 17'd22050, 17'd16000, 17'd12000, 17'd11025, 17'd8000,
		17'd7350, 17'd0, 17'd0, 17'd0
	};

	logic clk = 1'b0;
	logic arst_n;

	adtsd_in_if  in_ch();
	adtsd_out_if out_ch();

	adts_header_deframer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	deframe_phase_t      phase;
	logic [7:0]          last_byte;
	logic [2:0]          hdr_pos;
	logic [55:0]         hdr_bits;
	logic [LEN_W-1:0]    skip_left;
	logic [FNUM_W-1:0]   frame_count;
	logic [OFFSET_W-1:0] stream_pos;

	adtsd_result_t headers_due[$];
	adtsd_result_t got_hdr;

	int unsigned mismatches;
	int unsigned bytes_sent;
	int unsigned frames_seen;
	int unsigned short_frames;
	int unsigned quiet_cycles;
	bit          steady;

	function automatic void decode_byte(input logic [7:0] b);
		adtsd_result_t r;
		logic [7:0] b1, b2, b3, b4, b5;
		logic [LEN_W-1:0] len;
		case (phase)
			HEADER: begin
				hdr_bits = {hdr_bits[47:0], b};
				hdr_pos  = hdr_pos + 3'd1;
				if (hdr_pos == 3'd7) begin
					b1  = hdr_bits[47:40];
					b2  = hdr_bits[39:32];
					b3  = hdr_bits[31:24];
					b4  = hdr_bits[23:16];
					b5  = hdr_bits[15:8];
					len = {b3[1:0], b4, b5[7:5]};
					r.profile        = b2[7:6];
					r.sampling_index = b2[5:2];
					r.sample_rate_hz = RATE_LUT[b2[5:2]];
					r.channel_config = {b2[0], b3[7:6]};
					r.crc_absent     = b1[0];
					r.frame_length   = len;
					r.frame_number   = frame_count;
					r.frame_offset   = stream_pos - 32'd6;
					r.length_error   = (len < 13'd7);
					headers_due.push_back(r);
					frames_seen++;
					if (r.length_error)
						short_frames++;
					frame_count = frame_count + 1'b1;
					hdr_pos     = '0;
					last_byte   = '0;
					if (len <= 13'd7) begin
						phase     = HUNT;
						skip_left = '0;
					end else begin
						phase     = PAYLOAD;
						skip_left = len - 13'd7;
					end
				end
			end
			PAYLOAD: begin
				if (skip_left != '0)
					skip_left = skip_left - 1'b1;
				if (skip_left == '0) begin
					phase     = HUNT;
					last_byte = '0;
				end
			end
			default: begin
				phase = HUNT;
				if (last_byte == 8'hFF && b[7:4] == 4'hF) begin
					phase     = HEADER;
					hdr_bits  = {40'd0, 8'hFF, b};
					hdr_pos   = 3'd2;
					last_byte = '0;
				end else begin
					last_byte = b;
				end
			end
		endcase
		stream_pos = stream_pos + 1'b1;
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while (!steady && $urandom_range(0, 99) < 22) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.stream_byte <= b;
		do
			@(posedge clk);
		while (!in_ch.ready);
		decode_byte(b);
		bytes_sent++;
	endtask

	// header with the given fields and random filler bits, then random payload
	task automatic send_frame(input logic [1:0] profile, input logic [3:0] sidx,
			input logic [2:0] chcfg, input logic prot, input logic [12:0] len,
			input int unsigned payload_n);
		logic [7:0] hdr [7];
		hdr[0] = 8'hFF;
		hdr[1] = {4'hF, 3'($urandom), prot};
		hdr[2] = {profile, sidx, 1'($urandom), chcfg[2]};
		hdr[3] = {chcfg[1:0], 4'($urandom), len[12:11]};
		hdr[4] = len[10:3];
		hdr[5] = {len[2:0], 5'($urandom)};
		hdr[6] = 8'($urandom);
		foreach (hdr[i])
			send_byte(hdr[i]);
		repeat (payload_n)
			send_byte(8'($urandom));
	endtask

	task automatic test_length_extremes();
		// all-zero fields with a short length, then all-ones fields with exact header length
		send_frame(2'd0, 4'd0, 3'd0, 1'b0, 13'd0, 0);
		send_frame(2'd3, 4'd15, 3'd7, 1'b1, 13'd7, 0);
	endtask

	task automatic test_fresh_hunt();
		// last payload byte is 0xFF; the following 0xF1 must not be taken as sync
		send_frame(2'd1, 4'd3, 3'd2, 1'b1, 13'd8, 0);
		send_byte(8'hFF);
		send_byte(8'hF1);
	endtask

	task automatic test_random_stream();
		int unsigned start;
		int unsigned pick;
		int unsigned done;
		logic [12:0] len;
		start = bytes_sent;
		done  = 0;
		while (done < RANDOM_BYTES) begin
			steady = (done >= 300 && done < 500);
			pick   = $urandom_range(0, 99);
			if (pick < 80) begin
				pick = $urandom_range(0, 99);
				if (pick < 8)
					len = 13'($urandom_range(0, 6));
				else if (pick < 15)
					len = 13'd7;
				else if (pick < 90)
					len = 13'($urandom_range(8, 40));
				else
					len = 13'($urandom_range(41, 400));
				send_frame(2'($urandom), 4'($urandom), 3'($urandom), 1'($urandom), len,
					(len > 13'd7) ? int'(len) - 7 : 0);
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 6))
					send_byte(8'($urandom));
			end else begin
				// near-miss sync: 0xFF followed by a byte whose high nibble is not F
				send_byte(8'hFF);
				send_byte({4'($urandom_range(0, 14)), 4'($urandom)});
			end
			done = bytes_sent - start;
		end
		steady = 1'b0;
	endtask

	task automatic test_longest_frame();
		send_frame(2'($urandom), 4'($urandom), 3'($urandom), 1'($urandom), 13'd8191, 5);
	endtask

	// result checking
	function automatic void check_field(input string fname, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", fname, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (headers_due.size() == 0) begin
				$error("header result with no transaction expected");
				mismatches++;
			end else begin
				got_hdr = headers_due.pop_front();
				check_field("profile", got_hdr.profile, out_ch.profile);
				check_field("sampling_index", got_hdr.sampling_index, out_ch.sampling_index);
				check_field("sample_rate_hz", got_hdr.sample_rate_hz, out_ch.sample_rate_hz);
				check_field("channel_config", got_hdr.channel_config, out_ch.channel_config);
				check_field("crc_absent", got_hdr.crc_absent, out_ch.crc_absent);
				check_field("frame_length", got_hdr.frame_length, out_ch.frame_length);
				check_field("frame_number", got_hdr.frame_number, out_ch.frame_number);
				check_field("frame_offset", got_hdr.frame_offset, out_ch.frame_offset);
				check_field("length_error", got_hdr.length_error, out_ch.length_error);
			end
		end
	end

	always @(posedge clk) begin
		out_ch.ready <= steady || ($urandom_range(0, 99) >= 22);
	end

	// watchdog: cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("adts_header_deframer_top regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.stream_byte = '0;
		out_ch.ready      = 1'b0;
		steady            = 1'b0;
		mismatches        = 0;
		bytes_sent        = 0;
		frames_seen       = 0;
		short_frames      = 0;
		quiet_cycles      = 0;
		phase             = HUNT;
		last_byte         = '0;
		hdr_pos           = '0;
		hdr_bits          = '0;
		skip_left         = '0;
		frame_count       = '0;
		stream_pos        = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_length_extremes();
		test_fresh_hunt();
		test_random_stream();
		test_longest_frame();

		in_ch.valid <= 1'b0;
		while (headers_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Streamed %0d bytes: %0d headers decoded, %0d of them with a short length,",
			bytes_sent, frames_seen, short_frames);
		$display("with noise, near-miss sync pairs and random stalls on both channels.");
		if (mismatches == 0)
			$display("adts_header_deframer_top regression: pass");
		else
			$display("adts_header_deframer_top regression: fail");
		$finish;
	end

endmodule

FILE: sim.f
sv/adtsd_pkg.sv
sv/adtsd_in_if.sv
sv/adtsd_out_if.sv
sv/adtsd_parser.sv
sv/adtsd_out_stage.sv
sv/adts_header_deframer_top.sv
sv/adtsd_checker.sv
dv/tb_adts_header_deframer_top.sv
